[design/d2q9_pkg.sv]
// Package for the D2Q9 BGK node collision unit: payload structs, config
// register codes, direction tables and the saturation and digit-divide helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package d2q9_pkg;

  localparam int DW         = 32;
  localparam int NDIR       = 9;
  localparam int SATW       = 2 * DW + 40;
  localparam int OMEGA_W    = 31;
  localparam int FORCE_W    = 32;
  localparam int OMEGA_FRAC = 30;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RELAX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE = 1'b1;

  localparam logic [OMEGA_W-1:0] RELAX_RESET = 31'h4000_0000;

  localparam int DIR_EX  [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_EY  [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int WT_NUM  [NDIR] = '{4, 1, 1, 1, 1, 1, 1, 1, 1};
  localparam int WT_DEN  [NDIR] = '{9, 9, 9, 9, 9, 36, 36, 36, 36};
  localparam int WT_HALF [NDIR] = '{4, 4, 4, 4, 4, 18, 18, 18, 18};
  localparam int F_SIGN  [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};

  typedef struct packed {
    logic                 is_fluid;
    logic signed [DW-1:0] dist_0;
    logic signed [DW-1:0] dist_1;
    logic signed [DW-1:0] dist_2;
    logic signed [DW-1:0] dist_3;
    logic signed [DW-1:0] dist_4;
    logic signed [DW-1:0] dist_5;
    logic signed [DW-1:0] dist_6;
    logic signed [DW-1:0] dist_7;
    logic signed [DW-1:0] dist_8;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] post_0;
    logic signed [DW-1:0] post_1;
    logic signed [DW-1:0] post_2;
    logic signed [DW-1:0] post_3;
    logic signed [DW-1:0] post_4;
    logic signed [DW-1:0] post_5;
    logic signed [DW-1:0] post_6;
    logic signed [DW-1:0] post_7;
    logic signed [DW-1:0] post_8;
    logic signed [DW-1:0] density;
    logic signed [DW-1:0] velocity_x;
    logic signed [DW-1:0] velocity_y;
  } out_item_t;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SATW-1:0] x);
    logic signed [SATW-1:0] hi;
    logic signed [SATW-1:0] lo;
    hi = {{(SATW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = ~hi;
    if (x > hi) return {1'b0, {(DW-1){1'b1}}};
    if (x < lo) return {1'b1, {(DW-1){1'b0}}};
    return x[DW-1:0];
  endfunction

  // one radix-16 quotient digit and remainder for a divisor below 64
  function automatic logic [9:0] div_digit(input logic [9:0] num, input logic [5:0] den);
    logic [3:0] q;
    logic [9:0] rem;
    q = '0;
    for (int j = 1; j < 16; j++) begin
      if (num >= 10'(j) * {4'b0, den}) q = 4'(j);
    end
    rem = num - {6'b0, q} * {4'b0, den};
    return {q, rem[5:0]};
  endfunction

endpackage
`default_nettype wire

[design/d2q9_bgk_node_collision_unit.sv]
// Throughput: one node per cycle when not stalled; the two restoring dividers and
// the radix-16 weight dividers are fully pipelined, one quotient bit or digit per stage.
// Backpressure stalls the whole pipeline only while the output holds a result.
// Reset (rst_n low, synchronous) empties the pipeline and loads omega = 1.0, force = 0.
// Depends on d2q9_pkg.
`timescale 1ns / 1ps
`default_nettype none
module d2q9_bgk_node_collision_unit #(
  parameter int FRAC_BITS = 28
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire d2q9_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output d2q9_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [d2q9_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [d2q9_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DW   = d2q9_pkg::DW;
  localparam int SATW = d2q9_pkg::SATW;
  localparam int NW   = DW + FRAC_BITS;
  localparam int QW   = DW;
  localparam int TW   = (FRAC_BITS > DW) ? FRAC_BITS : DW;
  localparam int SW4  = DW + 4;
  localparam int DW2  = 2 * DW;
  localparam int RDW  = 2 * DW + 1;
  localparam int PW   = ((DW + 5 > FRAC_BITS + 2) ? DW + 5 : FRAC_BITS + 2) + 2;
  localparam int MW   = DW + 2;
  localparam int ND   = (MW + 3) / 4;
  localparam int MPW  = 4 * ND;
  localparam int D1   = DW + 1;
  localparam int KW   = DW + 33;
  localparam int LW   = KW + 3;
  localparam int NS   = QW + ND + 12;

  typedef struct packed {
    logic                fluid;
    logic [8:0][DW-1:0]  f;
    logic [DW-1:0]       rho;
    logic [DW-1:0]       ux;
    logic [DW-1:0]       uy;
  } carry_t;

  function automatic logic signed [RDW-1:0] rnd_fb(input logic signed [DW2-1:0] x);
    logic signed [RDW-1:0] t;
    t = RDW'(x) + (RDW'(1) <<< (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic [DW-1:0] fix_quot(input logic [QW-1:0] q, input logic ovf,
                                             input logic neg, input logic zero);
    if (zero) return '0;
    if (neg) begin
      if (ovf || q > {1'b1, {(DW-1){1'b0}}}) return {1'b1, {(DW-1){1'b0}}};
      return ~q + 1'b1;
    end
    if (ovf || q[DW-1]) return {1'b0, {(DW-1){1'b1}}};
    return q;
  endfunction

  // configuration
  logic [d2q9_pkg::OMEGA_W-1:0]        omega_r;
  logic signed [d2q9_pkg::FORCE_W-1:0] force_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r <= d2q9_pkg::RELAX_RESET;
      force_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        d2q9_pkg::REG_RELAX: omega_r <= cfg_data[d2q9_pkg::OMEGA_W-1:0];
        d2q9_pkg::REG_FORCE: force_r <= cfg_data[d2q9_pkg::FORCE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NS-1:0] vld_r;
  logic          adv;

  assign out_valid = vld_r[NS-1];
  assign adv       = !vld_r[NS-1] || !out_stall;
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // stage A: density and momentum
  logic signed [DW-1:0]  fin [9];
  logic signed [SW4-1:0] rho_s, mx_s, my_s;
  carry_t                ca_nxt, ca_r;
  logic signed [DW-1:0]  ca_mx_r, ca_my_r;

  assign fin[0] = in_data.dist_0;
  assign fin[1] = in_data.dist_1;
  assign fin[2] = in_data.dist_2;
  assign fin[3] = in_data.dist_3;
  assign fin[4] = in_data.dist_4;
  assign fin[5] = in_data.dist_5;
  assign fin[6] = in_data.dist_6;
  assign fin[7] = in_data.dist_7;
  assign fin[8] = in_data.dist_8;

  always_comb begin
    rho_s = '0;
    mx_s  = '0;
    my_s  = '0;
    ca_nxt = '0;
    ca_nxt.fluid = in_data.is_fluid;
    for (int k = 0; k < 9; k++) begin
      ca_nxt.f[k] = fin[k];
      rho_s = rho_s + SW4'(fin[k]);
      if (d2q9_pkg::DIR_EX[k] > 0) mx_s = mx_s + SW4'(fin[k]);
      if (d2q9_pkg::DIR_EX[k] < 0) mx_s = mx_s - SW4'(fin[k]);
      if (d2q9_pkg::DIR_EY[k] > 0) my_s = my_s + SW4'(fin[k]);
      if (d2q9_pkg::DIR_EY[k] < 0) my_s = my_s - SW4'(fin[k]);
    end
    ca_nxt.rho = d2q9_pkg::sat_dw(SATW'(rho_s));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ca_r    <= ca_nxt;
      ca_mx_r <= d2q9_pkg::sat_dw(SATW'(mx_s));
      ca_my_r <= d2q9_pkg::sat_dw(SATW'(my_s));
    end
  end

  // stage B and divider stages: |m| << FRAC_BITS / |rho|
  carry_t          dv_c_r    [QW+1];
  logic [DW-1:0]   dv_d_r    [QW+1];
  logic [DW-1:0]   dv_rx_r   [QW+1];
  logic [DW-1:0]   dv_ry_r   [QW+1];
  logic [QW-1:0]   dv_nx_r   [QW+1];
  logic [QW-1:0]   dv_ny_r   [QW+1];
  logic [QW-1:0]   dv_qx_r   [QW+1];
  logic [QW-1:0]   dv_qy_r   [QW+1];
  logic            dv_ovfx_r [QW+1];
  logic            dv_ovfy_r [QW+1];
  logic            dv_negx_r [QW+1];
  logic            dv_negy_r [QW+1];
  logic            dv_zero_r [QW+1];

  logic [DW-1:0]   b_d, b_mxa, b_mya;
  logic [NW-1:0]   b_nx, b_ny;
  logic [TW-1:0]   b_topx, b_topy;

  always_comb begin
    b_d    = ca_r.rho[DW-1] ? ~ca_r.rho + 1'b1 : ca_r.rho;
    b_mxa  = ca_mx_r[DW-1] ? ~ca_mx_r + 1'b1 : ca_mx_r;
    b_mya  = ca_my_r[DW-1] ? ~ca_my_r + 1'b1 : ca_my_r;
    b_nx   = {b_mxa, {FRAC_BITS{1'b0}}};
    b_ny   = {b_mya, {FRAC_BITS{1'b0}}};
    b_topx = TW'(b_nx[NW-1:QW]);
    b_topy = TW'(b_ny[NW-1:QW]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_c_r[0]    <= ca_r;
      dv_d_r[0]    <= b_d;
      dv_rx_r[0]   <= DW'(b_nx[NW-1:QW]);
      dv_ry_r[0]   <= DW'(b_ny[NW-1:QW]);
      dv_nx_r[0]   <= b_nx[QW-1:0];
      dv_ny_r[0]   <= b_ny[QW-1:0];
      dv_qx_r[0]   <= '0;
      dv_qy_r[0]   <= '0;
      dv_ovfx_r[0] <= b_topx >= TW'(b_d);
      dv_ovfy_r[0] <= b_topy >= TW'(b_d);
      dv_negx_r[0] <= ca_mx_r[DW-1] ^ ca_r.rho[DW-1];
      dv_negy_r[0] <= ca_my_r[DW-1] ^ ca_r.rho[DW-1];
      dv_zero_r[0] <= ca_r.rho == '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DW:0] sx, sy;
    logic        gex, gey;

    assign sx  = {dv_rx_r[j], dv_nx_r[j][QW-1]};
    assign sy  = {dv_ry_r[j], dv_ny_r[j][QW-1]};
    assign gex = sx >= {1'b0, dv_d_r[j]};
    assign gey = sy >= {1'b0, dv_d_r[j]};

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c_r[j+1]    <= dv_c_r[j];
        dv_d_r[j+1]    <= dv_d_r[j];
        dv_rx_r[j+1]   <= gex ? DW'(sx - {1'b0, dv_d_r[j]}) : sx[DW-1:0];
        dv_ry_r[j+1]   <= gey ? DW'(sy - {1'b0, dv_d_r[j]}) : sy[DW-1:0];
        dv_nx_r[j+1]   <= {dv_nx_r[j][QW-2:0], 1'b0};
        dv_ny_r[j+1]   <= {dv_ny_r[j][QW-2:0], 1'b0};
        dv_qx_r[j+1]   <= {dv_qx_r[j][QW-2:0], gex};
        dv_qy_r[j+1]   <= {dv_qy_r[j][QW-2:0], gey};
        dv_ovfx_r[j+1] <= dv_ovfx_r[j];
        dv_ovfy_r[j+1] <= dv_ovfy_r[j];
        dv_negx_r[j+1] <= dv_negx_r[j];
        dv_negy_r[j+1] <= dv_negy_r[j];
        dv_zero_r[j+1] <= dv_zero_r[j];
      end
    end
  end

  // stage C: signed, saturated velocity
  carry_t cc_nxt, cc_r;

  always_comb begin
    cc_nxt    = dv_c_r[QW];
    cc_nxt.ux = fix_quot(dv_qx_r[QW], dv_ovfx_r[QW], dv_negx_r[QW], dv_zero_r[QW]);
    cc_nxt.uy = fix_quot(dv_qy_r[QW], dv_ovfy_r[QW], dv_negy_r[QW], dv_zero_r[QW]);
  end

  always_ff @(posedge clk) begin
    if (adv) cc_r <= cc_nxt;
  end

  // stage D: direction projections, velocity squares
  carry_t                cd_r;
  logic signed [DW-1:0]  c_ux, c_uy;
  logic signed [DW+1:0]  cproj [9];
  logic signed [DW-1:0]  cdir_r [9];
  logic signed [DW2-1:0] uxx_r, uyy_r;

  assign c_ux = cc_r.ux;
  assign c_uy = cc_r.uy;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cproj[k] = '0;
      if (d2q9_pkg::DIR_EX[k] > 0) cproj[k] = cproj[k] + (DW+2)'(c_ux);
      if (d2q9_pkg::DIR_EX[k] < 0) cproj[k] = cproj[k] - (DW+2)'(c_ux);
      if (d2q9_pkg::DIR_EY[k] > 0) cproj[k] = cproj[k] + (DW+2)'(c_uy);
      if (d2q9_pkg::DIR_EY[k] < 0) cproj[k] = cproj[k] - (DW+2)'(c_uy);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cd_r  <= cc_r;
      uxx_r <= DW2'(c_ux) * DW2'(c_ux);
      uyy_r <= DW2'(c_uy) * DW2'(c_uy);
      for (int k = 0; k < 9; k++) cdir_r[k] <= d2q9_pkg::sat_dw(SATW'(cproj[k]));
    end
  end

  // stage E: usq, projection squares
  carry_t                ce_r;
  logic signed [DW-1:0]  usq_r;
  logic signed [DW-1:0]  cdir_e_r [9];
  logic signed [DW2-1:0] ccsq_r [9];
  logic signed [RDW:0]   usq_s;

  assign usq_s = (RDW+1)'(rnd_fb(uxx_r)) + (RDW+1)'(rnd_fb(uyy_r));

  always_ff @(posedge clk) begin
    if (adv) begin
      ce_r  <= cd_r;
      usq_r <= d2q9_pkg::sat_dw(SATW'(usq_s));
      for (int k = 0; k < 9; k++) begin
        cdir_e_r[k] <= cdir_r[k];
        ccsq_r[k]   <= DW2'(cdir_r[k]) * DW2'(cdir_r[k]);
      end
    end
  end

  // stage F: rounded projection squares
  carry_t               cf_r;
  logic signed [DW-1:0] usq_f_r;
  logic signed [DW-1:0] c_f_r [9];
  logic signed [DW-1:0] csq_r [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      cf_r    <= ce_r;
      usq_f_r <= usq_r;
      for (int k = 0; k < 9; k++) begin
        c_f_r[k] <= cdir_e_r[k];
        csq_r[k] <= d2q9_pkg::sat_dw(SATW'(rnd_fb(ccsq_r[k])));
      end
    end
  end

  // stage G: equilibrium polynomial
  carry_t               cg_r;
  logic signed [PW-1:0] half_s [9];
  logic signed [PW-1:0] poly_s [9];
  logic signed [DW-1:0] poly_r [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      half_s[k] = (PW'(csq_r[k]) * 9 - PW'(usq_f_r) * 3 + PW'(1)) >>> 1;
      poly_s[k] = (PW'(1) <<< FRAC_BITS) + PW'(c_f_r[k]) * 3 + half_s[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cg_r <= cf_r;
      for (int k = 0; k < 9; k++) poly_r[k] <= d2q9_pkg::sat_dw(SATW'(poly_s[k]));
    end
  end

  // stage H: rho * poly
  carry_t                ch_r;
  logic signed [DW-1:0]  g_rho;
  logic signed [DW2-1:0] prod_r [9];

  assign g_rho = cg_r.rho;

  always_ff @(posedge clk) begin
    if (adv) begin
      ch_r <= cg_r;
      for (int k = 0; k < 9; k++) prod_r[k] <= DW2'(g_rho) * DW2'(poly_r[k]);
    end
  end

  // stage I and digit stages: |p| * num + den/2, divided by den
  carry_t               dg_c_r   [ND+1];
  logic [MPW-1:0]       dg_m_r   [ND+1][9];
  logic [MPW-1:0]       dg_q_r   [ND+1][9];
  logic [5:0]           dg_rem_r [ND+1][9];
  logic                 dg_neg_r [ND+1][9];
  logic signed [DW-1:0] p_s  [9];
  logic [DW-1:0]        pa_s [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      p_s[k]  = d2q9_pkg::sat_dw(SATW'(rnd_fb(prod_r[k])));
      pa_s[k] = p_s[k][DW-1] ? ~p_s[k] + 1'b1 : p_s[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dg_c_r[0] <= ch_r;
      for (int k = 0; k < 9; k++) begin
        dg_m_r[0][k]   <= MPW'(pa_s[k]) * MPW'(d2q9_pkg::WT_NUM[k])
                          + MPW'(d2q9_pkg::WT_HALF[k]);
        dg_q_r[0][k]   <= '0;
        dg_rem_r[0][k] <= '0;
        dg_neg_r[0][k] <= p_s[k][DW-1];
      end
    end
  end

  for (genvar t = 0; t < ND; t++) begin : g_dig
    logic [9:0] dd [9];

    always_comb begin
      for (int k = 0; k < 9; k++) begin
        dd[k] = d2q9_pkg::div_digit({dg_rem_r[t][k], dg_m_r[t][k][MPW-1 -: 4]},
                                    6'(d2q9_pkg::WT_DEN[k]));
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dg_c_r[t+1] <= dg_c_r[t];
        for (int k = 0; k < 9; k++) begin
          dg_m_r[t+1][k]   <= {dg_m_r[t][k][MPW-5:0], 4'b0};
          dg_q_r[t+1][k]   <= {dg_q_r[t][k][MPW-5:0], dd[k][9:6]};
          dg_rem_r[t+1][k] <= dd[k][5:0];
          dg_neg_r[t+1][k] <= dg_neg_r[t][k];
        end
      end
    end
  end

  // stage J: feq - f
  carry_t                cj_r;
  logic signed [SATW-1:0] qs   [9];
  logic signed [DW-1:0]   feq  [9];
  logic signed [DW-1:0]   fj   [9];
  logic signed [D1-1:0]   diff_r [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      qs[k]  = $signed(SATW'(dg_q_r[ND][k]));
      feq[k] = d2q9_pkg::sat_dw(dg_neg_r[ND][k] ? -qs[k] : qs[k]);
      fj[k]  = dg_c_r[ND].f[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cj_r <= dg_c_r[ND];
      for (int k = 0; k < 9; k++) diff_r[k] <= D1'(feq[k]) - D1'(fj[k]);
    end
  end

  // stage K: omega * (feq - f)
  carry_t               ck_r;
  logic signed [KW-1:0] rp_r [9];
  logic signed [KW-1:0] om_s;

  assign om_s = KW'($signed({1'b0, omega_r}));

  always_ff @(posedge clk) begin
    if (adv) begin
      ck_r <= cj_r;
      for (int k = 0; k < 9; k++) rp_r[k] <= om_s * KW'(diff_r[k]);
    end
  end

  // stage L: relax, force, output register
  logic signed [LW-1:0] relax_s [9];
  logic signed [LW-1:0] v_s     [9];
  logic signed [DW-1:0] fl      [9];
  logic signed [DW-1:0] post_s  [9];
  d2q9_pkg::out_item_t  out_nxt, out_data_r;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      fl[k]      = ck_r.f[k];
      relax_s[k] = (LW'(rp_r[k]) + (LW'(1) <<< (d2q9_pkg::OMEGA_FRAC - 1)))
                   >>> d2q9_pkg::OMEGA_FRAC;
      v_s[k]     = LW'(fl[k]) + relax_s[k];
      if (d2q9_pkg::F_SIGN[k] > 0) v_s[k] = v_s[k] + LW'(force_r);
      if (d2q9_pkg::F_SIGN[k] < 0) v_s[k] = v_s[k] - LW'(force_r);
      post_s[k]  = ck_r.fluid ? d2q9_pkg::sat_dw(SATW'(v_s[k])) : fl[k];
    end
    out_nxt.post_0     = post_s[0];
    out_nxt.post_1     = post_s[1];
    out_nxt.post_2     = post_s[2];
    out_nxt.post_3     = post_s[3];
    out_nxt.post_4     = post_s[4];
    out_nxt.post_5     = post_s[5];
    out_nxt.post_6     = post_s[6];
    out_nxt.post_7     = post_s[7];
    out_nxt.post_8     = post_s[8];
    out_nxt.density    = ck_r.fluid ? ck_r.rho : '0;
    out_nxt.velocity_x = ck_r.fluid ? ck_r.ux : '0;
    out_nxt.velocity_y = ck_r.fluid ? ck_r.uy : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= out_nxt;
  end

  assign out_data = out_data_r;

endmodule
`default_nettype wire

[design/d2q9_chk.sv]
// Port-level checker for the D2Q9 BGK node collision unit, bound to the top level.
// Depends on d2q9_pkg and d2q9_bgk_node_collision_unit.
`timescale 1ns / 1ps
`default_nettype none
module d2q9_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire d2q9_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_zero_rho: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.density == '0 |->
      out_data.velocity_x == '0 && out_data.velocity_y == '0)
    else $error("velocity nonzero at zero density");

endmodule

bind d2q9_bgk_node_collision_unit d2q9_chk u_chk (.*);
`default_nettype wire
